// ===== src/kline_session_controller_defines.svh =====
// Assertion macros shared by the session controller checker.
`ifndef KLINE_SESSION_CONTROLLER_DEFINES_SVH
`define KLINE_SESSION_CONTROLLER_DEFINES_SVH

// Concurrent check on the rising clock edge, suspended while reset is high.
`define KSC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Concurrent check on the rising clock edge that also holds across reset.
`define KSC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== src/kline_sc_pkg.sv =====
// Shared types, constants and request tables of the K-line session controller.
package kline_sc_pkg;

   // Most request bytes sent on one tick.
   localparam int MAX_REQUEST_BYTES = 7;
   localparam int TXC_W = $clog2(MAX_REQUEST_BYTES + 1);

   // Job queue between the front and back parts.
   localparam int JOBQ_DEPTH = 4;
   localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
   localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

   localparam int SENT_W = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Session states.
   localparam logic [1:0] ST_INIT    = 2'd0;
   localparam logic [1:0] ST_START   = 2'd1;
   localparam logic [1:0] ST_ACTIVE  = 2'd2;
   localparam logic [1:0] ST_STOPPED = 2'd3;

   // Input item kinds.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;
   localparam logic [1:0] KIND_STOP  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_IDLE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RSP_TIMEOUT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_GAP   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_LIMIT = 3'd4;

   // Request frames: start communication and read sensors.
   localparam logic [SENT_W-1:0] START_LEN = 3'd5;
   localparam logic [SENT_W-1:0] READ_LEN  = 3'd7;
   localparam logic [7:0] START_REQ [5] = '{8'h81, 8'h12, 8'hF1, 8'h81, 8'h05};
   localparam logic [7:0] READ_REQ  [7] = '{8'h80, 8'h12, 8'hF1, 8'h02, 8'h21, 8'h08, 8'hAE};

   // One accepted item, classified and ready to be expanded into results.
   typedef struct packed {
      logic [TXC_W-1:0]  tx_count;
      logic [SENT_W-1:0] tx_first;
      logic              read_req;
      logic              line_low;
      logic              data_valid;
      logic [7:0]        data_byte;
      logic              frame_done;
      logic              frame_good;
      logic              timed_out;
      logic [1:0]        state;
   } job_type;

   // One result item.
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       line_forced_low;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       frame_done;
      logic       frame_good;
      logic       timed_out;
      logic [1:0] session_state;
      logic       last;
   } result_type;

   function automatic logic [7:0] request_byte(input logic read_sel,
                                               input logic [SENT_W-1:0] idx);
      logic [7:0] value;
      value = 8'h00;
      if (read_sel) begin
         if (idx < READ_LEN) value = READ_REQ[idx];
      end else if (idx < START_LEN) begin
         value = START_REQ[idx];
      end
      return value;
   endfunction

endpackage

// ===== src/kline_sc_jobq.sv =====
// Short job queue that decouples the classifying front from the result back.
module kline_sc_jobq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  kline_sc_pkg::job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output kline_sc_pkg::job_type head_job,
   output logic                 empty
);
   import kline_sc_pkg::*;

   job_type                slot_ff [JOBQ_DEPTH];
   logic [JOBQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [JOBQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [JOBQ_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == JOBQ_CNT_W'(JOBQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// ===== src/kline_sc_front.sv =====
// Front part: configuration registers, session state and item classification.
module kline_sc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [kline_sc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kline_sc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                                 item_valid,
   input  logic [1:0]                           kind,
   input  logic [7:0]                           rx_byte,
   output kline_sc_pkg::job_type                job
);
   import kline_sc_pkg::*;

   // Configuration.
   logic [15:0] init_idle_ff;
   logic [9:0]  pulse_ff;
   logic [15:0] timeout_ff;
   logic [15:0] gap_ticks_ff;
   logic [7:0]  error_limit_ff;

   // Session state.
   logic [1:0]        phase_ff, phase_in;
   logic [16:0]       elapsed_ff, elapsed_in;
   logic [15:0]       gap_ff, gap_in;
   logic [15:0]       idle_ff, idle_in;
   logic [SENT_W-1:0] sent_ff, sent_in;
   logic [8:0]        recv_ff, recv_in;
   logic [7:0]        flen_ff, flen_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        mism_ff, mism_in;

   logic [16:0]       wake_end, pulse_end, t_low;
   logic [15:0]       gap_inc, idle_inc;
   logic [SENT_W-1:0] req_len;
   logic [TXC_W-1:0]  remain, burst;
   logic [8:0]        recv_inc, pos, frame_end;
   logic [7:0]        flen_eff, mism_inc;
   logic              clear_frame, wake_done;

   always_comb begin
      wake_end  = {1'b0, init_idle_ff} + {6'b0, pulse_ff, 1'b0};
      pulse_end = {1'b0, init_idle_ff} + {7'b0, pulse_ff};
      gap_inc   = (gap_ff == 16'hFFFF) ? gap_ff : gap_ff + 16'd1;
      idle_inc  = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      req_len   = (phase_ff == ST_START) ? START_LEN : READ_LEN;
      remain    = TXC_W'(req_len) - TXC_W'(sent_ff);
      burst     = (remain > TXC_W'(MAX_REQUEST_BYTES)) ? TXC_W'(MAX_REQUEST_BYTES) : remain;
      recv_inc  = (recv_ff == 9'h1FF) ? recv_ff : recv_ff + 9'd1;
      pos       = recv_inc - {6'b0, sent_ff};
      flen_eff  = (pos == 9'd4) ? rx_byte : flen_ff;
      frame_end = {1'b0, flen_eff} + 9'd5;
      mism_inc  = (mism_ff == 8'hFF) ? mism_ff : mism_ff + 8'd1;

      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      gap_in      = gap_ff;
      idle_in     = idle_ff;
      sent_in     = sent_ff;
      recv_in     = recv_ff;
      flen_in     = flen_ff;
      sum_in      = sum_ff;
      mism_in     = mism_ff;
      clear_frame = 1'b0;
      wake_done   = 1'b0;
      job         = '0;

      if (item_valid) begin
         case (kind)
            KIND_TICK: begin
               if (phase_ff == ST_INIT) begin
                  if (elapsed_ff >= wake_end) begin
                     clear_frame = 1'b1;
                     wake_done   = 1'b1;
                     phase_in    = ST_START;
                  end
                  if (elapsed_ff != 17'h1FFFF) elapsed_in = elapsed_ff + 17'd1;
               end else if (phase_ff inside {ST_START, ST_ACTIVE}) begin
                  gap_in       = gap_inc;
                  idle_in      = idle_inc;
                  job.read_req = (phase_ff == ST_ACTIVE);
                  if (sent_ff < req_len && gap_inc >= gap_ticks_ff) begin
                     job.tx_count = burst;
                     job.tx_first = sent_ff;
                     sent_in      = sent_ff + SENT_W'(burst);
                  end
                  if (idle_inc > timeout_ff) begin
                     clear_frame   = 1'b1;
                     job.timed_out = 1'b1;
                     if (phase_ff == ST_START) begin
                        phase_in   = ST_INIT;
                        elapsed_in = '0;
                     end else begin
                        phase_in = ST_START;
                     end
                  end
               end
            end
            KIND_BYTE: begin
               if (phase_ff inside {ST_START, ST_ACTIVE}) begin
                  idle_in = '0;
                  recv_in = recv_inc;
                  // Bytes up to the number sent are our own echo.
                  if (recv_inc > {6'b0, sent_ff}) begin
                     if (pos == 9'd4) flen_in = rx_byte;
                     if (phase_ff == ST_ACTIVE) begin
                        job.data_valid = 1'b1;
                        job.data_byte  = rx_byte;
                     end
                     if (pos < frame_end) begin
                        sum_in = sum_ff + rx_byte;
                     end else if (pos == frame_end) begin
                        job.frame_done = 1'b1;
                        job.frame_good = (sum_ff == rx_byte);
                        clear_frame    = 1'b1;
                        if (phase_ff == ST_START) begin
                           if (sum_ff == rx_byte) begin
                              phase_in = ST_ACTIVE;
                           end else begin
                              phase_in   = ST_INIT;
                              elapsed_in = '0;
                           end
                        end else if (sum_ff == rx_byte) begin
                           mism_in = '0;
                        end else begin
                           mism_in = mism_inc;
                           if (mism_inc >= error_limit_ff) phase_in = ST_START;
                        end
                     end
                  end
               end
            end
            KIND_START: begin
               if (phase_ff == ST_STOPPED) begin
                  phase_in   = ST_INIT;
                  elapsed_in = '0;
               end
            end
            KIND_STOP: begin
               phase_in = ST_STOPPED;
            end
            default: ;
         endcase
      end

      if (clear_frame) begin
         sent_in = '0;
         recv_in = '0;
         flen_in = '0;
         sum_in  = '0;
         idle_in = '0;
         gap_in  = '0;
      end
      // After the wake pattern the inter-frame gap counts as already elapsed.
      if (wake_done) gap_in = 16'hFFFF;

      t_low        = elapsed_in - 17'd1;
      job.line_low = (phase_in == ST_INIT) && (elapsed_in != '0) &&
                     (t_low >= {1'b0, init_idle_ff}) && (t_low < pulse_end);
      job.state    = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_idle_ff   <= 16'd6000;
         pulse_ff       <= 10'd25;
         timeout_ff     <= 16'd500;
         gap_ticks_ff   <= 16'd200;
         error_limit_ff <= 8'd5;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INIT_IDLE:   init_idle_ff   <= csr_wdata;
            CSR_PULSE:       pulse_ff       <= csr_wdata[9:0];
            CSR_RSP_TIMEOUT: timeout_ff     <= csr_wdata;
            CSR_FRAME_GAP:   gap_ticks_ff   <= csr_wdata;
            CSR_ERROR_LIMIT: error_limit_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ST_STOPPED;
         elapsed_ff <= '0;
         gap_ff     <= '0;
         idle_ff    <= '0;
         sent_ff    <= '0;
         recv_ff    <= '0;
         flen_ff    <= '0;
         sum_ff     <= '0;
         mism_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         gap_ff     <= gap_in;
         idle_ff    <= idle_in;
         sent_ff    <= sent_in;
         recv_ff    <= recv_in;
         flen_ff    <= flen_in;
         sum_ff     <= sum_in;
         mism_ff    <= mism_in;
      end
   end

endmodule

// ===== src/kline_sc_back.sv =====
// Back part: expands each job into result items and holds the output register.
module kline_sc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  kline_sc_pkg::job_type   job,
   input  logic                    job_empty,
   output logic                    job_pop,
   output kline_sc_pkg::result_type rsp,
   output logic                    rsp_empty,
   input  logic                    rsp_pop
);
   import kline_sc_pkg::*;

   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, out_in;
   logic [TXC_W-1:0] k_ff, k_in;
   logic [TXC_W-1:0] n_res;
   logic             advance, emit, is_last;

   assign advance   = !out_valid_ff || rsp_pop;
   assign emit      = advance && !job_empty;
   assign n_res     = (job.tx_count == '0) ? TXC_W'(1) : job.tx_count;
   assign is_last   = (k_ff == n_res - TXC_W'(1));
   assign job_pop   = emit && is_last;
   assign rsp       = out_ff;
   assign rsp_empty = !out_valid_ff;

   always_comb begin
      out_in.tx_valid        = (job.tx_count != '0);
      out_in.tx_byte         = out_in.tx_valid ?
                               request_byte(job.read_req, job.tx_first + SENT_W'(k_ff)) : 8'h00;
      out_in.line_forced_low = job.line_low;
      out_in.data_valid      = job.data_valid;
      out_in.data_byte       = job.data_byte;
      out_in.frame_done      = job.frame_done;
      out_in.frame_good      = job.frame_good;
      out_in.timed_out       = job.timed_out && is_last;
      out_in.session_state   = job.state;
      out_in.last            = is_last;

      out_valid_in = emit || (out_valid_ff && !rsp_pop);
      k_in         = k_ff;
      if (emit) k_in = is_last ? '0 : k_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) out_ff <= out_in;
   end

endmodule

// ===== src/kline_session_controller.sv =====
// Top level of the K-line fast-init diagnostic session controller.
//
// Input queue side: req_kind and req_rx_byte carry one event (millisecond tick,
// received line byte, start, stop); a transfer happens on a clock edge with
// req_push high and req_full low. Result queue side: while rsp_empty is low the
// oldest result sits on the rsp_ ports and a transfer happens on an edge with
// rsp_pop high. Every event yields one result; a tick that releases a request
// burst yields one result per request byte, up to seven, and rsp_last marks the
// final result of each event. Configuration registers are written through
// csr_we, csr_index and csr_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce. An event's job passes
// the job queue and then the output register before its first result reaches
// the rsp_ ports. Throughput: one event per cycle is taken while req_full is
// low; the back part emits one result per cycle while the receiver keeps taking
// results, so a burst tick occupies it until all its bytes are out. The
// four-entry job queue between front and back absorbs such bursts, and req_full
// rises once it fills. When the receiver stalls, the held result stays on the
// ports, the job queue fills and then req_full holds off new events. Reset
// (synchronous, active high) restores register defaults, enters the stopped state and empties both queues.
module kline_session_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [1:0]                           req_kind,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_tx_valid,
   output logic [7:0]                           rsp_tx_byte,
   output logic                                 rsp_line_forced_low,
   output logic                                 rsp_data_valid,
   output logic [7:0]                           rsp_data_byte,
   output logic                                 rsp_frame_done,
   output logic                                 rsp_frame_good,
   output logic                                 rsp_timed_out,
   output logic [1:0]                           rsp_session_state,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [kline_sc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kline_sc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import kline_sc_pkg::*;

   job_type    front_job, head_job;
   result_type result;
   logic       q_full, q_empty, q_pop, accept;

   // An event is taken whenever the job queue has room.
   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   // The front updates the session state and emits one job per accepted event.
   kline_sc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (accept),
      .kind       (req_kind),
      .rx_byte    (req_rx_byte),
      .job        (front_job)
   );

   kline_sc_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (front_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   // The back turns each job into its results and holds the output register.
   kline_sc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .job_empty (q_empty),
      .job_pop   (q_pop),
      .rsp       (result),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_tx_valid        = result.tx_valid;
   assign rsp_tx_byte         = result.tx_byte;
   assign rsp_line_forced_low = result.line_forced_low;
   assign rsp_data_valid      = result.data_valid;
   assign rsp_data_byte       = result.data_byte;
   assign rsp_frame_done      = result.frame_done;
   assign rsp_frame_good      = result.frame_good;
   assign rsp_timed_out       = result.timed_out;
   assign rsp_session_state   = result.session_state;
   assign rsp_last            = result.last;

endmodule

// ===== src/kline_sc_checker.sv =====
// Port-level checker for the session controller, bound to the top level.
`include "kline_session_controller_defines.svh"

module kline_sc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_push,
   input logic                                 req_full,
   input logic [1:0]                           req_kind,
   input logic [7:0]                           req_rx_byte,
   input logic                                 rsp_empty,
   input logic                                 rsp_pop,
   input logic                                 rsp_tx_valid,
   input logic [7:0]                           rsp_tx_byte,
   input logic                                 rsp_line_forced_low,
   input logic                                 rsp_data_valid,
   input logic [7:0]                           rsp_data_byte,
   input logic                                 rsp_frame_done,
   input logic                                 rsp_frame_good,
   input logic                                 rsp_timed_out,
   input logic [1:0]                           rsp_session_state,
   input logic                                 rsp_last,
   input logic                                 csr_we,
   input logic [kline_sc_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [kline_sc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import kline_sc_pkg::*;

   // Reset leaves no result pending.
   `KSC_ASSERT_ALWAYS(a_reset_empty, reset |=> rsp_empty, "result pending after reset")

   // A stalled result keeps its payload.
   `KSC_ASSERT(a_stall_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_tx_byte) && $stable(rsp_session_state) && $stable(rsp_last)), "stalled result changed")

   // The wake pulse is only driven during init.
   `KSC_ASSERT(a_low_in_init, (!rsp_empty && rsp_line_forced_low) |-> (rsp_session_state == ST_INIT), "line low outside init")

   // A forwarded response byte is the single result of its event and sends nothing.
   `KSC_ASSERT(a_data_single, (!rsp_empty && rsp_data_valid) |-> (rsp_last && !rsp_tx_valid), "data result not single")

   // The timeout flag rides on the final result of its tick.
   `KSC_ASSERT(a_timeout_last, (!rsp_empty && rsp_timed_out) |-> rsp_last, "timeout not on final result")

endmodule

bind kline_session_controller kline_sc_checker u_kline_sc_checker (.*);

// ===== tb/sv/kline_session_controller_tb.sv =====
// Self-checking testbench of the K-line fast-init session controller.
module kline_session_controller_tb;
   import kline_sc_pkg::*;

   // Most results that one event can cause, and the settle time after draining.
   localparam int RESULT_MAX    = 7;
   localparam int SETTLE_CYCLES = 8;

   // Request frames as they must appear on the line.
   localparam logic [7:0] START_COMM_BYTES [5] = '{8'h81, 8'h12, 8'hF1, 8'h81, 8'h05};
   localparam logic [7:0] READ_SENSOR_BYTES [7] =
      '{8'h80, 8'h12, 8'hF1, 8'h02, 8'h21, 8'h08, 8'hAE};

   // One expected result, field by field as on the rsp_ ports.
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       line_forced_low;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       frame_done;
      logic       frame_good;
      logic       timed_out;
      logic [1:0] session_state;
      logic       last;
   } session_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [1:0] req_kind = KIND_TICK;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_line_forced_low;
   logic       rsp_data_valid;
   logic [7:0] rsp_data_byte;
   logic       rsp_frame_done;
   logic       rsp_frame_good;
   logic       rsp_timed_out;
   logic [1:0] rsp_session_state;
   logic       rsp_last;
   logic       csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_INIT_IDLE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   kline_session_controller dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_kind            (req_kind),
      .req_rx_byte         (req_rx_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_line_forced_low (rsp_line_forced_low),
      .rsp_data_valid      (rsp_data_valid),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_frame_done      (rsp_frame_done),
      .rsp_frame_good      (rsp_frame_good),
      .rsp_timed_out       (rsp_timed_out),
      .rsp_session_state   (rsp_session_state),
      .rsp_last            (rsp_last),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mirror of the register file, at the widths of the registers.
   logic [15:0] idle_high_ticks = 16'd6000;
   logic [9:0]  pulse_len       = 10'd25;
   logic [15:0] timeout_ticks   = 16'd500;
   logic [15:0] gap_min         = 16'd200;
   logic [7:0]  bad_limit       = 8'd5;

   // Mirror of the session state as it stands after the last accepted event.
   logic [1:0]  sess_state   = ST_STOPPED;
   logic [16:0] wake_ticks   = '0;
   logic [15:0] gap_ticks    = '0;
   logic [15:0] silent_ticks = '0;
   logic [2:0]  tx_sent      = '0;
   logic [8:0]  rx_seen      = '0;
   logic [7:0]  rsp_len      = '0;
   logic [7:0]  rsp_sum      = '0;
   logic [7:0]  bad_streak   = '0;

   // Results that the block owes us, oldest first.
   session_result_type pending_results [$];

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;

   int event_count   = 0;
   int result_count  = 0;
   int good_frames   = 0;
   int bad_frames    = 0;
   int timeout_count = 0;
   int error_count   = 0;

   function automatic logic [2:0] request_len();
      return (sess_state == ST_START) ? 3'd5 : 3'd7;
   endfunction

   function automatic logic [7:0] tx_table_byte(input logic [1:0] st, input logic [2:0] idx);
      if (st == ST_START) begin
         return (idx < 3'd5) ? START_COMM_BYTES[idx] : 8'h00;
      end
      return READ_SENSOR_BYTES[idx];
   endfunction

   // The wake pulse is low for pulse_len ticks once the idle-high time has passed.
   function automatic logic wake_line_low();
      logic [16:0] t;
      if (sess_state != ST_INIT || wake_ticks == '0) return 1'b0;
      t = wake_ticks - 17'd1;
      return (32'(t) >= 32'(idle_high_ticks)) &&
             (32'(t) < 32'(idle_high_ticks) + 32'(pulse_len));
   endfunction

   // Drops whatever part of a request/response exchange was in flight.
   task automatic restart_frame();
      tx_sent      = '0;
      rx_seen      = '0;
      rsp_len      = '0;
      rsp_sum      = '0;
      silent_ticks = '0;
      gap_ticks    = '0;
   endtask

   // Advances the session mirror by one accepted event and queues its results.
   task automatic predict_session_results(input logic [1:0] kind, input logic [7:0] value);
      session_result_type res [RESULT_MAX];
      int n;
      int k;
      logic [2:0] req_len;
      logic [8:0] pos;
      logic good;
      logic low;
      n = 0;
      for (k = 0; k < RESULT_MAX; k++) res[k] = '0;
      case (kind)
         KIND_TICK: begin
            if (sess_state == ST_INIT) begin
               // The wake pattern is complete: the line may now carry a request.
               if (32'(wake_ticks) >= 32'(idle_high_ticks) + 2 * 32'(pulse_len)) begin
                  restart_frame();
                  gap_ticks  = 16'hFFFF;
                  sess_state = ST_START;
               end
               if (wake_ticks != 17'h1FFFF) wake_ticks++;
            end else if (sess_state != ST_STOPPED) begin
               req_len = request_len();
               if (gap_ticks != 16'hFFFF) gap_ticks++;
               if (silent_ticks != 16'hFFFF) silent_ticks++;
               if (tx_sent < req_len && gap_ticks >= gap_min) begin
                  while (tx_sent < req_len && n < RESULT_MAX) begin
                     res[n].tx_valid = 1'b1;
                     res[n].tx_byte  = tx_table_byte(sess_state, tx_sent);
                     n++;
                     tx_sent++;
                  end
               end
               // A timeout falls back one state and is flagged on the tick's final result.
               if (silent_ticks > timeout_ticks) begin
                  restart_frame();
                  if (sess_state == ST_START) begin
                     sess_state = ST_INIT;
                     wake_ticks = '0;
                  end else begin
                     sess_state = ST_START;
                  end
                  if (n == 0) n = 1;
                  res[n-1].timed_out = 1'b1;
                  timeout_count++;
               end
            end
         end
         KIND_BYTE: begin
            if (sess_state == ST_START || sess_state == ST_ACTIVE) begin
               silent_ticks = '0;
               if (rx_seen != 9'h1FF) rx_seen++;
               // Bytes up to the number sent are our own echo and are skipped.
               if (rx_seen > 9'(tx_sent)) begin
                  pos = rx_seen - 9'(tx_sent);
                  if (pos == 9'd4) rsp_len = value;
                  if (sess_state == ST_ACTIVE) begin
                     res[0].data_valid = 1'b1;
                     res[0].data_byte  = value;
                  end
                  if (32'(pos) < 32'(rsp_len) + 5) begin
                     rsp_sum = rsp_sum + value;
                  end else if (32'(pos) == 32'(rsp_len) + 5) begin
                     good = (rsp_sum == value);
                     res[0].frame_done = 1'b1;
                     res[0].frame_good = good;
                     restart_frame();
                     if (good) good_frames++;
                     else bad_frames++;
                     if (sess_state == ST_START) begin
                        if (good) begin
                           sess_state = ST_ACTIVE;
                        end else begin
                           sess_state = ST_INIT;
                           wake_ticks = '0;
                        end
                     end else if (good) begin
                        bad_streak = '0;
                     end else begin
                        if (bad_streak != 8'hFF) bad_streak++;
                        if (bad_streak >= bad_limit) sess_state = ST_START;
                     end
                  end
               end
            end
         end
         KIND_START: begin
            if (sess_state == ST_STOPPED) begin
               sess_state = ST_INIT;
               wake_ticks = '0;
            end
         end
         default: sess_state = ST_STOPPED;
      endcase
      if (n == 0) n = 1;
      low = wake_line_low();
      for (k = 0; k < n; k++) begin
         res[k].line_forced_low = low;
         res[k].session_state   = sess_state;
         res[k].last            = (k == n - 1);
         pending_results.push_back(res[k]);
      end
      event_count++;
   endtask

   // Offers one event at the falling edge and holds it until a transfer happens.
   task automatic send_event(input logic [1:0] kind, input logic [7:0] value);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push    = 1'b1;
      req_kind    = kind;
      req_rx_byte = value;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_session_results(kind, value);
   endtask

   task automatic send_tick();
      send_event(KIND_TICK, 8'($urandom_range(255)));
   endtask

   task automatic send_byte(input logic [7:0] value);
      send_event(KIND_BYTE, value);
   endtask

   // Stops offering events and waits until every owed result has been taken.
   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         CSR_INIT_IDLE:   idle_high_ticks = data;
         CSR_PULSE:       pulse_len       = data[9:0];
         CSR_RSP_TIMEOUT: timeout_ticks   = data;
         CSR_FRAME_GAP:   gap_min         = data;
         CSR_ERROR_LIMIT: bad_limit       = data[7:0];
         default: ;
      endcase
   endtask

   // Rewrites all five registers once the block has gone quiet.
   task automatic set_timing(input int init_idle, input int pulse, input int timeout,
                             input int gap, input int limit);
      wait_drained();
      write_register(CSR_INIT_IDLE, 16'(init_idle));
      write_register(CSR_PULSE, 16'(pulse));
      write_register(CSR_RSP_TIMEOUT, 16'(timeout));
      write_register(CSR_FRAME_GAP, 16'(gap));
      write_register(CSR_ERROR_LIMIT, 16'(limit));
   endtask

   task automatic ticks_until_state(input logic [1:0] target);
      while (sess_state != target) send_tick();
   endtask

   task automatic ticks_until_request_sent();
      while ((sess_state == ST_START || sess_state == ST_ACTIVE) && tx_sent < request_len())
         send_tick();
   endtask

   // Plays back the echo of the request, then a response of len data bytes whose
   // checksum is right or deliberately wrong.
   task automatic answer_request(input int len, input bit corrupt);
      int i;
      while (rx_seen < 9'(tx_sent)) send_byte(tx_table_byte(sess_state, rx_seen[2:0]));
      for (i = 0; i < 3; i++) send_byte(8'($urandom_range(255)));
      send_byte(8'(len));
      for (i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
      send_byte(rsp_sum ^ (corrupt ? 8'h3C : 8'h00));
   endtask

   task automatic complete_read_cycle(input int len, input bit corrupt);
      ticks_until_request_sent();
      answer_request(len, corrupt);
   endtask

   // Walks the session from wherever it is up to the active state.
   task automatic enter_active();
      while (sess_state != ST_ACTIVE) begin
         if (sess_state == ST_STOPPED) begin
            send_event(KIND_START, 8'h00);
         end else if (sess_state == ST_INIT) begin
            send_tick();
         end else begin
            complete_read_cycle(0, 1'b0);
         end
      end
   endtask

   // One random event: mostly the next step of a well-formed session with random
   // content, sometimes a stray event or a broken checksum. Bytes that the block
   // merely ignores are not counted.
   task automatic random_event(output bit counted);
      logic [1:0] kind;
      logic [7:0] value;
      int next_pos;
      int roll;
      kind  = KIND_TICK;
      value = 8'($urandom_range(255));
      roll  = $urandom_range(99);
      if (roll < 10) begin
         kind = 2'($urandom_range(3));
      end else if (sess_state == ST_STOPPED) begin
         kind = KIND_START;
      end else if (sess_state == ST_INIT || tx_sent < request_len() || roll < 25) begin
         kind = KIND_TICK;
      end else begin
         kind     = KIND_BYTE;
         next_pos = int'(rx_seen) + 1 - int'(tx_sent);
         if (next_pos <= 0) begin
            if ($urandom_range(99) < 90) value = tx_table_byte(sess_state, rx_seen[2:0]);
         end else if (next_pos == 4) begin
            value = ($urandom_range(99) < 95) ? 8'($urandom_range(6)) :
                                                8'($urandom_range(24, 7));
         end else if (next_pos >= 5 && next_pos == int'(rsp_len) + 5) begin
            value = ($urandom_range(99) < 75) ? rsp_sum :
                                                rsp_sum ^ 8'($urandom_range(255, 1));
         end
      end
      counted = !(kind == KIND_BYTE && (sess_state == ST_STOPPED || sess_state == ST_INIT));
      send_event(kind, value);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Test tasks.
   // ------------------------------------------------------------------------

   // Events in the stopped and init states: status only, bytes ignored, start
   // honored only while stopped, stop from anywhere.
   task automatic test_quiet_states();
      send_tick();
      send_byte(8'hFF);
      send_event(KIND_STOP, 8'h00);
      send_byte(8'h00);
      send_event(KIND_START, 8'hFF);
      send_event(KIND_START, 8'h5A);
      send_byte(8'hA5);
      send_event(KIND_STOP, 8'h00);
   endtask

   // Idle high, low pulse and high pulse, then the move to start session.
   task automatic test_wake_pattern();
      send_event(KIND_START, 8'h00);
      ticks_until_state(ST_START);
   endtask

   // Start-communication request, its echo, and a good reply.
   task automatic test_start_request();
      ticks_until_request_sent();
      answer_request(0, 1'b0);
   endtask

   // Full seven-byte read burst with forwarded response data.
   task automatic test_read_request();
      complete_read_cycle(3, 1'b0);
   endtask

   // The mismatch count runs up to the limit, a good frame clears it, and a bad
   // reply in start session drops back to the wake pattern.
   task automatic test_checksum_errors();
      complete_read_cycle(1, 1'b1);
      complete_read_cycle(0, 1'b0);
      complete_read_cycle(1, 1'b1);
      complete_read_cycle(2, 1'b1);
      ticks_until_request_sent();
      answer_request(0, 1'b1);
   endtask

   // Timeouts in both session states, once on the same tick as a request burst.
   task automatic test_timeouts();
      set_timing(2, 1, 1, 2, 2);
      ticks_until_state(ST_INIT);
      enter_active();
      ticks_until_state(ST_START);
      ticks_until_state(ST_INIT);
      set_timing(2, 1, 3, 0, 2);
      enter_active();
      ticks_until_request_sent();
      ticks_until_state(ST_START);
   endtask

   // Largest idle-high, timeout, gap and limit values with a long pulse: the longest
   // idle-high time keeps the line high through the first ticks of the wake pattern.
   task automatic test_register_extremes();
      set_timing(65535, 1000, 65535, 65535, 255);
      send_event(KIND_STOP, 8'h00);
      send_event(KIND_START, 8'h00);
      repeat (4) send_tick();
      send_event(KIND_STOP, 8'h00);
   endtask

   // Zero pulse length and zero error limit: no wake pulse at all, and a restart
   // on the first mismatch in the active state.
   task automatic test_zero_registers();
      set_timing(1, 0, 65535, 0, 0);
      enter_active();
      complete_read_cycle(0, 1'b1);
   endtask

   // Random sessions under four mixes of sender idling and receiver stalling,
   // each with its own small timing.
   task automatic test_random_sessions();
      int phase_idx;
      int done;
      bit counted;
      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         set_timing($urandom_range(4), $urandom_range(3, 1), $urandom_range(12, 2),
                    $urandom_range(3), $urandom_range(4, 1));
         case (phase_idx)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
            default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
         endcase
         done = 0;
         while (done < 8) begin
            random_event(counted);
            if (counted) done++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver: pops at random at the falling edge; every transfer is checked at
   // the rising edge against the oldest owed result.
   // ------------------------------------------------------------------------
   always @(negedge clock) rsp_pop = ($urandom_range(99) >= rx_stall_pct);

   always @(posedge clock) begin : result_checker
      session_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         result_count++;
         if (pending_results.size() == 0) begin
            $error("result transfer with no result owed (state %0d)", rsp_session_state);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("tx_valid", 8'(want.tx_valid), 8'(rsp_tx_valid));
            check_field("tx_byte", want.tx_byte, rsp_tx_byte);
            check_field("line_forced_low", 8'(want.line_forced_low),
                        8'(rsp_line_forced_low));
            check_field("data_valid", 8'(want.data_valid), 8'(rsp_data_valid));
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("frame_done", 8'(want.frame_done), 8'(rsp_frame_done));
            check_field("frame_good", 8'(want.frame_good), 8'(rsp_frame_good));
            check_field("timed_out", 8'(want.timed_out), 8'(rsp_timed_out));
            check_field("session_state", 8'(want.session_state), 8'(rsp_session_state));
            check_field("last", 8'(want.last), 8'(rsp_last));
         end
      end
   end

   // Main sequence. Reset is released at a falling edge.
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_timing(2, 1, 6, 0, 2);
      test_quiet_states();
      test_wake_pattern();
      test_start_request();
      test_read_request();
      test_checksum_errors();
      test_timeouts();
      test_register_extremes();
      test_zero_registers();
      test_random_sessions();

      wait_drained();
      if (pending_results.size() != 0) begin
         $error("%0d results still owed at the end", pending_results.size());
         error_count++;
      end
      $display("Checked %0d results from %0d events: %0d good and %0d bad frames, %0d timeouts.",
               result_count, event_count, good_frames, bad_frames, timeout_count);
      $display("Covered wake timing, both requests, zero and largest registers, four idling mixes.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #400_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== kline_session_controller.f =====
+incdir+src
src/kline_sc_pkg.sv
src/kline_sc_jobq.sv
src/kline_sc_front.sv
src/kline_sc_back.sv
src/kline_session_controller.sv
src/kline_sc_checker.sv
tb/sv/kline_session_controller_tb.sv
